[hdl/swft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swft_pkg
// shared constants and types for the sorted word frequency table
// ----------------------------------------------------------------------------
package swft_pkg;
    localparam int MaxEntries = 64;
    localparam int WordBytes  = 9;
    localparam int CountBits  = 16;
    localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int UsedW      = $clog2(MaxEntries + 1);
    localparam int HeadShift  = (WordBytes >= 8) ? 0 : 8 * (8 - WordBytes);
    localparam logic [63:0] HeadMask = ~64'd0 << HeadShift;
    localparam logic [7:0]  TailMask = (WordBytes >= 9) ? 8'hFF : 8'h00;
    localparam logic [CountBits-1:0] CountMax = '1;
    localparam int KeyW = 72;
    localparam int EntW = KeyW + CountBits;

    typedef enum logic [2:0] {
        t_idle, t_scan, t_upd, t_emit_scan, t_emit_out, t_emit_wait
    } t_state;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;
endpackage

[hdl/swft_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swft_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module swft_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hdl/sorted_word_frequency_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_word_frequency_table
// bounded word table with saturating counts, emitted in sorted order
// ----------------------------------------------------------------------------
// Entries sit in one single-port memory read one entry per cycle. An add
// walks the used entries and stalls the input while it scans and then
// updates the table. A flush of n entries runs n selection passes, each a
// scan of the used entries followed by the output handshake; a flush of an
// empty table emits nothing. The table then reads empty at once.
module sorted_word_frequency_table
    import swft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [63:0] i_word_head,
    input  logic [7:0]  i_word_tail,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_word_head,
    output logic [7:0]  o_out_word_tail,
    output logic [15:0] o_occurrences,
    output logic        o_overflowed,
    output logic        o_last_entry
);
    t_state r_state, n_state;
    logic [UsedW-1:0] r_used, r_ptr, r_pass;
    logic [IdxW-1:0]  r_hit_idx;
    logic             r_hit, r_best_ok, r_rd_ok, r_drop, r_have_last;
    logic [KeyW-1:0]  r_key, r_best_key, r_last_key;
    logic [CountBits-1:0] r_best_cnt;
    logic [IdxW-1:0]  r_rd_idx;

    logic             mem_we;
    logic [IdxW-1:0]  mem_addr;
    logic [EntW-1:0]  mem_wdata, mem_rdata;
    logic [KeyW-1:0]  rd_key;
    logic [CountBits-1:0] rd_cnt;

    swft_ram #(.Width(EntW), .Depth(1 << IdxW)) u_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    assign rd_key = mem_rdata[EntW-1 -: KeyW];
    assign rd_cnt = mem_rdata[CountBits-1:0];

    // candidate: strictly above last emitted key (ties impossible, keys distinct)
    logic cand, better;
    assign cand   = !r_have_last || (rd_key > r_last_key);
    assign better = !r_best_ok || (rd_key < r_best_key);

    logic accept, out_free;
    assign out_free = !o_valid || !i_stall;
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != t_idle);

    logic scan_end;
    assign scan_end = (r_ptr >= r_used);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_idle: begin
                if (accept) begin
                    n_state = (i_req_type == REQ_FLUSH) ? t_emit_scan : t_scan;
                end
            end
            t_scan:      if (scan_end && !r_rd_ok) n_state = t_upd;
            t_upd:       n_state = t_idle;
            t_emit_scan: begin
                if (scan_end && !r_rd_ok) n_state = r_best_ok ? t_emit_out : t_idle;
            end
            t_emit_out:  if (out_free) n_state = t_emit_wait;
            t_emit_wait: n_state = (r_pass >= r_used) ? t_idle : t_emit_scan;
            default:     n_state = t_idle;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_ptr[IdxW-1:0];
        mem_wdata = {r_key, CountBits'(1)};
        if (r_state == t_upd) begin
            if (r_hit) begin
                mem_addr  = r_hit_idx;
                mem_we    = (r_best_cnt != CountMax);
                mem_wdata = {r_key, r_best_cnt + CountBits'(1)};
            end else begin
                mem_addr = r_used[IdxW-1:0];
                mem_we   = (r_used < UsedW'(MaxEntries));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle;
            r_used  <= '0;
            r_drop  <= 1'b0;
            o_valid <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && !i_stall && r_state != t_emit_out) o_valid <= 1'b0;
            r_rd_ok  <= (r_state == t_scan || r_state == t_emit_scan) && !scan_end;
            r_rd_idx <= r_ptr[IdxW-1:0];
            unique case (r_state)
                t_idle: begin
                    r_ptr <= '0;
                    r_hit <= 1'b0;
                    r_best_ok <= 1'b0;
                    r_have_last <= 1'b0;
                    r_pass <= '0;
                    r_key <= {i_word_head & HeadMask, i_word_tail & TailMask};
                end
                t_scan, t_emit_scan: begin
                    if (!scan_end) begin
                        r_ptr <= r_ptr + UsedW'(1);
                    end
                    if (r_rd_ok) begin
                        if (r_state == t_scan) begin
                            if (rd_key == r_key) begin
                                r_hit <= 1'b1;
                                r_hit_idx <= r_rd_idx;
                                r_best_cnt <= rd_cnt;
                            end
                        end else if (cand && better) begin
                            r_best_ok  <= 1'b1;
                            r_best_key <= rd_key;
                            r_best_cnt <= rd_cnt;
                        end
                    end
                    if (r_state == t_emit_scan && scan_end && !r_rd_ok && !r_best_ok) begin
                        r_used <= '0;
                        r_drop <= 1'b0;
                    end
                end
                t_upd: begin
                    if (!r_hit) begin
                        if (r_used < UsedW'(MaxEntries)) r_used <= r_used + UsedW'(1);
                        else r_drop <= 1'b1;
                    end
                end
                t_emit_out: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        o_out_word_head <= r_best_key[KeyW-1:8];
                        o_out_word_tail <= r_best_key[7:0];
                        o_occurrences <= (CountBits > 16 && r_best_cnt > 65535)
                            ? 16'hFFFF : 16'(r_best_cnt);
                        o_overflowed <= r_drop;
                        o_last_entry <= (r_pass + UsedW'(1) >= r_used);
                        r_pass <= r_pass + UsedW'(1);
                        r_last_key <= r_best_key;
                        r_have_last <= 1'b1;
                    end
                end
                t_emit_wait: begin
                    r_ptr <= '0;
                    r_best_ok <= 1'b0;
                    if (r_pass >= r_used) begin
                        r_used <= '0;
                        r_drop <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[hdl/swft_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swft_checker
// port level checks for the sorted word frequency table
// ----------------------------------------------------------------------------
module swft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_out_word_head,
    input logic        o_last_entry
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_word_head))
        else $error("stalled beat changed");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_entry |-> o_stall)
        else $error("input taken during emit");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("no stall after accepted beat");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind sorted_word_frequency_table swft_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out_word_head(o_out_word_head),
    .o_last_entry(o_last_entry)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sorted word frequency table.
// Words are added and the table is flushed through the valid/stall input
// channel. A local copy of the table predicts each flushed entry: its word,
// its saturating count, the dropped-word flag and the last marker. Every
// output beat is checked in order against that prediction. Both channels
// idle at random, with two long stretches without idling.
// ----------------------------------------------------------------------------
module tb_top
    import swft_pkg::*;
();

    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic [63:0] head;
        logic [7:0]  tail;
        logic [15:0] count;
        logic        ovf;
        logic        last;
    } t_flush_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = REQ_ADD;
    logic [63:0] i_word_head = '0;
    logic [7:0]  i_word_tail = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_out_word_head;
    logic [7:0]  o_out_word_tail;
    logic [15:0] o_occurrences;
    logic        o_overflowed;
    logic        o_last_entry;

    sorted_word_frequency_table DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // table copy
    logic [63:0]          tbl_head [MaxEntries];
    logic [7:0]           tbl_tail [MaxEntries];
    logic [CountBits-1:0] tbl_count [MaxEntries];
    int                   tbl_used;
    logic                 tbl_dropped;

    t_flush_beat pending_beats[$];
    int  errors;
    bit  quiet;
    int  watch;
    logic [63:0] pool_head [16];
    logic [7:0]  pool_tail [16];

    task automatic predict_add(input logic [63:0] head_in, input logic [7:0] tail_in);
        logic [63:0] h;
        logic [7:0]  t;
        h = head_in & HeadMask;
        t = tail_in & TailMask;
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_head[i] == h && tbl_tail[i] == t) begin
                if (tbl_count[i] != CountMax) tbl_count[i]++;
                return;
            end
        end
        if (tbl_used >= MaxEntries) begin
            tbl_dropped = 1'b1;
        end else begin
            tbl_head[tbl_used]  = h;
            tbl_tail[tbl_used]  = t;
            tbl_count[tbl_used] = CountBits'(1);
            tbl_used++;
        end
    endtask

    task automatic predict_flush();
        bit done [MaxEntries];
        int best;
        t_flush_beat b;
        for (int i = 0; i < MaxEntries; i++) done[i] = 0;
        for (int k = 0; k < tbl_used; k++) begin
            best = -1;
            for (int i = 0; i < tbl_used; i++) begin
                if (!done[i] && (best < 0 ||
                        {tbl_head[i], tbl_tail[i]} < {tbl_head[best], tbl_tail[best]}))
                    best = i;
            end
            done[best] = 1;
            b.head  = tbl_head[best];
            b.tail  = tbl_tail[best];
            b.count = (tbl_count[best] > 16'hFFFF) ? 16'hFFFF : tbl_count[best];
            b.ovf   = tbl_dropped;
            b.last  = (k == tbl_used - 1);
            pending_beats.push_back(b);
        end
        tbl_used = 0;
        tbl_dropped = 1'b0;
    endtask

    task automatic send_beat(input logic req, input logic [63:0] head,
                             input logic [7:0] tail);
        if (!quiet && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_word_head <= head;
        i_word_tail <= tail;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        if (req == REQ_FLUSH) predict_flush();
        else predict_add(head, tail);
    endtask

    task automatic push_word(input logic [63:0] head, input logic [7:0] tail);
        send_beat(REQ_ADD, head, tail);
    endtask

    task automatic flush_table();
        send_beat(REQ_FLUSH, {$urandom, $urandom}, 8'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (MaxEntries + 10) @(posedge i_clk);
    endtask

    // output side
    always @(posedge i_clk) begin
        t_flush_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $display("%0t unexpected beat head=%h tail=%h", $time,
                         o_out_word_head, o_out_word_tail);
                errors++;
            end else begin
                e = pending_beats.pop_front();
                if (o_out_word_head !== e.head) begin
                    $display("%0t head exp %h got %h", $time, e.head, o_out_word_head);
                    errors++;
                end
                if (o_out_word_tail !== e.tail) begin
                    $display("%0t tail exp %h got %h", $time, e.tail, o_out_word_tail);
                    errors++;
                end
                if (o_occurrences !== e.count) begin
                    $display("%0t count exp %0d got %0d", $time, e.count, o_occurrences);
                    errors++;
                end
                if (o_overflowed !== e.ovf) begin
                    $display("%0t overflow exp %b got %b", $time, e.ovf, o_overflowed);
                    errors++;
                end
                if (o_last_entry !== e.last) begin
                    $display("%0t last exp %b got %b", $time, e.last, o_last_entry);
                    errors++;
                end
            end
        end
        i_stall <= !quiet && ($urandom_range(99) < 20);
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) watch <= 0;
        else watch <= watch + 1;
        if (watch >= WatchLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed();
        flush_table();
        push_word('0, '0);
        push_word('1, 8'hFF);
        push_word(64'h4142_4300_0000_0000, 8'h00);
        push_word(64'h4142_4300_0000_0000, 8'h01);
        push_word(64'h4100_4200_0000_0000, 8'h00);
        push_word(64'h4142_4300_0000_0000, 8'h00);
        push_word('0, '0);
        push_word(64'h8000_0000_0000_0000, 8'h00);
        push_word(64'h0000_0000_0000_0001, 8'h80);
        flush_table();
        flush_table();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MaxEntries; i++)
            push_word({$urandom, 24'h0, i[7:0]}, 8'($urandom));
        push_word(64'hFFFF_0000_1111_2222, 8'h33);
        push_word(tbl_head[3], tbl_tail[3]);
        flush_table();
        push_word(64'h6869_0000_0000_0000, 8'h00);
        flush_table();
    endtask

    task automatic test_repeats();
        quiet = 1;
        for (int i = 0; i < 40; i++) push_word(64'h7361_7475_7261_7465, 8'h64);
        push_word(64'h6F6E_6365_0000_0000, 8'h00);
        flush_table();
        quiet = 0;
    endtask

    task automatic test_random();
        int r;
        for (int i = 0; i < 16; i++) begin
            pool_head[i] = {$urandom, $urandom};
            pool_tail[i] = 8'($urandom);
        end
        for (int n = 0; n < 150; n++) begin
            if (n == 60) quiet = 1;
            if (n == 110) quiet = 0;
            if (n == 140) drain();
            r = $urandom_range(99);
            if (r < 7) flush_table();
            else if (r < 70) push_word(pool_head[$urandom_range(15)],
                                       pool_tail[$urandom_range(15)]);
            else push_word({$urandom, $urandom}, 8'($urandom));
        end
        flush_table();
    endtask

    initial begin
        errors = 0;
        quiet = 0;
        tbl_used = 0;
        tbl_dropped = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_repeats();
        test_random();
        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

[files.f]
hdl/swft_pkg.sv
hdl/swft_ram.sv
hdl/sorted_word_frequency_table.sv
hdl/swft_checker.sv
dv/tb_top.sv
